// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared clocked assertion forms used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that also holds while reset is high.
`define ASSERT_CLK_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- design/pbp_pkg.sv -----
// ----------------------------------------------------------------------------
// Perceptron branch predictor package
// Sizes, constants and the sequencer state type of the predictor.
// ----------------------------------------------------------------------------
package pbp_pkg;

  localparam int HISTORY_LENGTH = 16;
  localparam int INDEX_BITS     = 8;

  localparam int PC_W      = 64;
  localparam int WEIGHT_W  = 8;
  localparam int THR_W     = 7;
  localparam int SUM_OUT_W = 13;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(44);

  localparam int ROWS       = 1 << INDEX_BITS;
  localparam int ROW_WIDTH  = HISTORY_LENGTH + 1;
  localparam int WMEM_DEPTH = ROWS * ROW_WIDTH;
  localparam int IDX_W      = $clog2(ROW_WIDTH);
  localparam int ADDR_W     = $clog2(WMEM_DEPTH);
  localparam int TAG_W      = PC_W - INDEX_BITS - 2;

  // Enough bits for the largest possible dot product, never less than the output.
  localparam int SUM_W = $clog2(ROW_WIDTH * (1 << (WEIGHT_W - 1)) + 1) + 1;
  localparam int ACC_W = (SUM_W > SUM_OUT_W) ? SUM_W : SUM_OUT_W;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HISTORY_LENGTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_SUM_LAST,
    ST_DECIDE,
    ST_TRAIN,
    ST_TRAIN_LAST
  } pbp_state_t;

endpackage

// ----- design/perceptron_branch_predictor_top.sv -----
// ----------------------------------------------------------------------------
// Perceptron branch predictor
// One shared adder first sums the selected row's weights against the global
// history, then walks the row again to train and write back every weight.
// ----------------------------------------------------------------------------
// The result strobe is registered from the decide step after the sum pass and
// comes while the training pass still runs. A new request is taken only once
// the last one has finished training, as the single adder and the weight memory
// visit every weight of the row twice. busy is high for the whole request.
// Reset (synchronous, rst high) clears all row valid bits at once, so weights
// and tags read as zero until written; history clears and the threshold is 44.
module perceptron_branch_predictor_top import pbp_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [PC_W-1:0]             branch_pc,
  input  logic                        taken,
  output logic                        busy,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [THR_W-1:0]            cfg_data,
  output logic                        result_valid,
  output logic                        predicted_taken,
  output logic                        mispredicted,
  output logic                        tag_conflict,
  output logic signed [SUM_OUT_W-1:0] perceptron_sum
);

  pbp_state_t state, state_next;

  logic [IDX_W-1:0]         cnt;
  logic                     rd_vld;
  logic [IDX_W-1:0]         rd_idx;
  logic signed [ACC_W-1:0]  acc;
  logic [INDEX_BITS-1:0]    row_reg;
  logic [ADDR_W-1:0]        base_addr;
  logic [TAG_W-1:0]         tag_reg;
  logic                     taken_reg;
  logic                     train_reg;
  logic [HISTORY_LENGTH-1:0] hist;
  logic [THR_W-1:0]         thr;
  logic [ROWS-1:0]          row_valid;

  logic [WEIGHT_W-1:0] wmem [WMEM_DEPTH];
  logic [WEIGHT_W-1:0] w_rdata;
  logic [TAG_W-1:0]    tmem [ROWS];
  logic [TAG_W-1:0]    tag_rdata;

  // Sequencer controls
  logic accept, w_re, w_we, tag_re, tag_we, res_load, acc_en, finish;

  // Datapath
  logic [ADDR_W-1:0]        w_raddr, w_waddr;
  logic signed [WEIGHT_W-1:0] w_cur;
  logic signed [ACC_W-1:0]  w_ext;
  logic [ROW_WIDTH-1:0]     hx;
  logic                     hx_bit;
  logic signed [ACC_W-1:0]  op_a, op_b, add_out;
  logic signed [ACC_W-1:0]  thr_hi, thr_lo, clamped;
  logic [WEIGHT_W-1:0]      new_w;
  logic                     pred, mis, in_margin;
  logic                     row_hit;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:       if (start) state_next = ST_SUM;
      ST_SUM:        if (cnt == LAST_IDX) state_next = ST_SUM_LAST;
      ST_SUM_LAST:   state_next = ST_DECIDE;
      ST_DECIDE:     state_next = ST_TRAIN;
      ST_TRAIN:      if (cnt == LAST_IDX) state_next = ST_TRAIN_LAST;
      ST_TRAIN_LAST: state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    accept   = 1'b0;
    w_re     = 1'b0;
    w_we     = 1'b0;
    tag_re   = 1'b0;
    tag_we   = 1'b0;
    res_load = 1'b0;
    acc_en   = 1'b0;
    finish   = 1'b0;
    unique case (state)
      ST_IDLE: accept = start;
      ST_SUM: begin
        w_re   = 1'b1;
        tag_re = 1'b1;
        acc_en = rd_vld;
      end
      ST_SUM_LAST: acc_en = rd_vld;
      ST_DECIDE: begin
        tag_we   = 1'b1;
        res_load = 1'b1;
      end
      ST_TRAIN: begin
        w_re = 1'b1;
        w_we = rd_vld;
      end
      ST_TRAIN_LAST: begin
        w_we   = rd_vld;
        finish = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // A row that was never written holds zero weights and a zero tag.
  assign row_hit = row_valid[row_reg];
  assign w_cur   = row_hit ? w_rdata : '0;
  assign w_ext   = ACC_W'(w_cur);

  // The bias sees a constant +1 history element in position zero.
  assign hx     = {hist, 1'b1};
  assign hx_bit = hx[rd_idx];

  assign thr_hi = ACC_W'(thr);
  assign thr_lo = ~thr_hi;

  // Shared adder: accumulates during the sum pass, steps weights during training.
  always_comb begin
    if (state == ST_TRAIN || state == ST_TRAIN_LAST) begin
      op_a = w_ext;
      op_b = (taken_reg == hx_bit) ? ACC_W'(1) : '1;
    end else begin
      op_a = acc;
      op_b = hx_bit ? w_ext : -w_ext;
    end
  end

  assign add_out = op_a + op_b;

  always_comb begin
    if (add_out > thr_hi) begin
      clamped = thr_hi;
    end else if (add_out < thr_lo) begin
      clamped = thr_lo;
    end else begin
      clamped = add_out;
    end
  end

  // Untrained rows are still written back so a fresh row ends up holding zeros.
  assign new_w = train_reg ? clamped[WEIGHT_W-1:0] : w_cur;

  assign pred      = ~acc[ACC_W-1];
  assign mis       = pred ^ taken_reg;
  assign in_margin = (acc <= thr_hi) && (acc >= -thr_hi);

  assign w_raddr = base_addr + ADDR_W'(cnt);
  assign w_waddr = base_addr + ADDR_W'(rd_idx);

  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[w_waddr] <= new_w;
    end
    if (w_re) begin
      w_rdata <= wmem[w_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tmem[row_reg] <= tag_reg;
    end
    if (tag_re) begin
      tag_rdata <= tmem[row_reg];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld       <= 1'b0;
      result_valid <= 1'b0;
      row_valid    <= '0;
      hist         <= '0;
      thr          <= THR_RESET;
      cnt          <= '0;
    end else begin
      rd_vld       <= w_re;
      result_valid <= res_load;
      if (accept || res_load) begin
        cnt <= '0;
      end else if (w_re) begin
        cnt <= cnt + IDX_W'(1);
      end
      if (cfg_valid && cfg_ready) begin
        thr <= cfg_data;
      end
      if (finish) begin
        row_valid[row_reg] <= 1'b1;
        hist               <= HISTORY_LENGTH'({taken_reg, hist} >> 1);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rd_idx <= cnt;
    if (accept) begin
      row_reg   <= branch_pc[INDEX_BITS+1:2];
      tag_reg   <= branch_pc[PC_W-1:INDEX_BITS+2];
      base_addr <= ADDR_W'(branch_pc[INDEX_BITS+1:2]) * ADDR_W'(ROW_WIDTH);
      taken_reg <= taken;
      acc       <= '0;
    end else if (acc_en) begin
      acc <= add_out;
    end
    if (res_load) begin
      train_reg       <= mis || in_margin;
      predicted_taken <= pred;
      mispredicted    <= mis;
      tag_conflict    <= row_hit ? (tag_rdata != tag_reg) : (tag_reg != '0);
      perceptron_sum  <= acc[SUM_OUT_W-1:0];
    end
  end

endmodule

// ----- design/pbp_checker.sv -----
// ----------------------------------------------------------------------------
// Perceptron branch predictor checker
// Watches the request and result ports of the predictor over time.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pbp_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic result_valid
);

  // A result belongs to a request that is still in progress.
  `ASSERT_CLK(a_result_in_busy, result_valid |-> busy, "result strobe outside a request")

  // An accepted request makes the block busy on the next cycle.
  `ASSERT_CLK(a_accept_busy, (start && !busy) |=> busy, "accepted request did not start")

  // Each request produces a single one-cycle strobe.
  `ASSERT_CLK(a_single_strobe, result_valid |=> !result_valid, "result strobe repeated")

  // Reset leaves the block idle with no result pending.
  `ASSERT_CLK_RST(a_reset_idle, rst |=> (!busy && !result_valid), "not idle after reset")

endmodule

bind perceptron_branch_predictor_top pbp_checker u_pbp_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid)
);

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// Perceptron branch predictor testbench
// Drives resolved branches through the command port and keeps its own
// perceptron table, tag table and global history to predict every result.
// Directed branches, threshold extremes and long random program traces with
// aliasing rows run under several threshold settings. Each result is checked
// field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import pbp_pkg::*;

  localparam int CYCLE_LIMIT       = 400000;
  localparam int LATENCY_SLACK     = 40;
  localparam int BRANCH_POOL       = 24;
  localparam int RANDOM_PHASES     = 5;
  localparam int ITEMS_PER_PHASE   = 136;
  localparam int BACK_TO_BACK_TAIL = 120;

  typedef struct packed {
    logic                        taken_pred;
    logic                        mispred;
    logic                        conflict;
    logic signed [SUM_OUT_W-1:0] dot;
  } branch_result_t;

  // How a branch of the random program trace resolves.
  typedef enum int {
    B_ALWAYS,
    B_NEVER,
    B_ALTERNATE,
    B_LOOP4,
    B_ECHO2,
    B_XOR,
    B_RANDOM
  } branch_habit_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        start = 1'b0;
  logic [PC_W-1:0]             branch_pc = '0;
  logic                        taken = 1'b0;
  logic                        busy;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [THR_W-1:0]            cfg_data = '0;
  logic                        result_valid;
  logic                        predicted_taken;
  logic                        mispredicted;
  logic                        tag_conflict;
  logic signed [SUM_OUT_W-1:0] perceptron_sum;

  // Predictor state mirrored by the testbench.
  logic signed [WEIGHT_W-1:0] weights_m [ROWS][ROW_WIDTH];
  logic [TAG_W-1:0]           tags_m [ROWS];
  logic [HISTORY_LENGTH-1:0]  history_m;
  logic [THR_W-1:0]           threshold_m;

  branch_result_t pending_predictions[$];

  int error_count      = 0;
  int items_sent       = 0;
  int results_checked  = 0;
  int settings_written = 0;
  int mispredict_seen  = 0;
  int conflict_seen    = 0;
  int cycle_count      = 0;

  perceptron_branch_predictor_top u_dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .branch_pc       (branch_pc),
    .taken           (taken),
    .busy            (busy),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .result_valid    (result_valid),
    .predicted_taken (predicted_taken),
    .mispredicted    (mispredicted),
    .tag_conflict    (tag_conflict),
    .perceptron_sum  (perceptron_sum)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  function automatic int saturate_weight(int v);
    int hi;
    int lo;
    hi = int'(threshold_m);
    lo = -hi - 1;
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Predicts one branch and applies the training and history update.
  function automatic branch_result_t predict_and_train(logic [PC_W-1:0] pc, logic tk);
    branch_result_t   res;
    logic [TAG_W-1:0] tag;
    int               row;
    int               acc;
    int               wv;
    int               dir;
    int               thr;
    row = int'(pc[INDEX_BITS+1:2]);
    tag = pc[PC_W-1:INDEX_BITS+2];
    res.conflict = (tags_m[row] != tag);
    tags_m[row] = tag;
    acc = weights_m[row][0];
    for (int i = 0; i < HISTORY_LENGTH; i++) begin
      wv = weights_m[row][i+1];
      acc += history_m[i] ? wv : -wv;
    end
    res.taken_pred = (acc >= 0);
    res.mispred    = (res.taken_pred != tk);
    res.dot        = SUM_OUT_W'(acc);
    thr = int'(threshold_m);
    dir = tk ? 1 : -1;
    if (res.mispred || (acc <= thr && acc >= -thr)) begin
      weights_m[row][0] = WEIGHT_W'(saturate_weight(int'(weights_m[row][0]) + dir));
      for (int i = 0; i < HISTORY_LENGTH; i++) begin
        wv = weights_m[row][i+1];
        weights_m[row][i+1] = WEIGHT_W'(saturate_weight(wv + (history_m[i] ? dir : -dir)));
      end
    end
    history_m = {tk, history_m[HISTORY_LENGTH-1:1]};
    return res;
  endfunction

  // start stays high on return so that a following request goes out back to back.
  task automatic send_branch(input logic [PC_W-1:0] pc, input logic tk);
    start     <= 1'b1;
    branch_pc <= pc;
    taken     <= tk;
    do @(posedge clk); while (busy !== 1'b0);
    pending_predictions.push_back(predict_and_train(pc, tk));
    items_sent++;
  endtask

  task automatic idle_cycles(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (pending_predictions.size() != 0 || busy !== 1'b0);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] thr);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= thr;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid   <= 1'b0;
    threshold_m = thr;
    settings_written++;
  endtask

  always @(posedge clk) begin : check_results
    branch_result_t want;
    if (!rst && result_valid === 1'b1) begin
      if (pending_predictions.size() == 0) begin
        $error("result strobe with no request outstanding");
        error_count++;
      end else begin
        want = pending_predictions.pop_front();
        results_checked++;
        if (want.mispred) mispredict_seen++;
        if (want.conflict) conflict_seen++;
        if (predicted_taken !== want.taken_pred) begin
          $error("predicted_taken: expected %0d, actual %0d", want.taken_pred, predicted_taken);
          error_count++;
        end
        if (mispredicted !== want.mispred) begin
          $error("mispredicted: expected %0d, actual %0d", want.mispred, mispredicted);
          error_count++;
        end
        if (tag_conflict !== want.conflict) begin
          $error("tag_conflict: expected %0d, actual %0d", want.conflict, tag_conflict);
          error_count++;
        end
        if (perceptron_sum !== want.dot) begin
          $error("perceptron_sum: expected %0d, actual %0d", want.dot, perceptron_sum);
          error_count++;
        end
      end
    end
  end

  // Zero sum, both row extremes, tag changes in both directions, ignored low
  // address bits, and repeated training of one row at the reset threshold.
  task automatic test_directed();
    send_branch(64'h0, 1'b0);
    send_branch(64'h0, 1'b1);
    send_branch(64'h3FC, 1'b1);
    send_branch('1, 1'b1);
    send_branch('1, 1'b0);
    send_branch(64'h8000_0000_0000_0000, 1'b0);
    send_branch(64'h3, 1'b1);
    send_branch(64'h400, 1'b1);
    send_branch(64'h5555_5555_5555_5555, 1'b0);
    send_branch(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
    for (int k = 0; k < 8; k++) send_branch(64'h0000_1234_5678_9AB0, 1'b1);
    for (int k = 0; k < 4; k++) send_branch(64'h0000_1234_5678_9AB0, k[0]);
    idle_cycles(1);
  endtask

  // Threshold 0 pins weights to [-1, 0]; threshold 127 lets them grow, and a
  // drop to 1 afterwards forces clamping of already large weights.
  task automatic test_threshold_extremes();
    logic [PC_W-1:0] pc;
    logic            tk;
    write_threshold(THR_W'(0));
    for (int k = 0; k < 30; k++) begin
      pc = PC_W'(64'h1000 + (k % 4) * 4);
      tk = (k % 3 != 0);
      if ($urandom_range(0, 3) == 0) tk = 1'($urandom_range(0, 1));
      send_branch(pc, tk);
    end
    write_threshold(THR_W'(127));
    for (int k = 0; k < 60; k++) begin
      pc = PC_W'(64'h2000 + (k % 2) * 4);
      tk = (k % 2 == 0) ? 1'b1 : 1'((k / 2) % 2);
      if ($urandom_range(0, 7) == 0) tk = ~tk;
      send_branch(pc, tk);
    end
    write_threshold(THR_W'(1));
    for (int k = 0; k < 30; k++) begin
      pc = PC_W'(64'h2000 + (k % 2) * 4);
      tk = 1'($urandom_range(0, 1));
      send_branch(pc, tk);
    end
    idle_cycles(1);
  endtask

  // Random program traces: a pool of branches with fixed habits, half of them
  // sharing a row with another branch, mixed with fully random requests.
  task automatic test_random_traffic();
    logic [PC_W-1:0]  pool_pc [BRANCH_POOL];
    branch_habit_t    pool_habit [BRANCH_POOL];
    int               pool_seen [BRANCH_POOL];
    logic [THR_W-1:0] plan [RANDOM_PHASES];
    logic [7:0]       recent;
    logic [PC_W-1:0]  pc;
    logic             tk;
    int               cur;
    bit               late;
    recent = '0;
    cur    = 0;
    for (int i = 0; i < BRANCH_POOL; i++) begin
      pool_pc[i] = {$urandom, $urandom};
      if (i >= BRANCH_POOL / 2)
        pool_pc[i][INDEX_BITS+1:0] = pool_pc[i-BRANCH_POOL/2][INDEX_BITS+1:0];
      if ($urandom_range(0, 3) == 0) pool_pc[i][PC_W-1:INDEX_BITS+2] = '0;
      pool_habit[i] = branch_habit_t'($urandom_range(0, 6));
      pool_seen[i]  = 0;
    end
    plan[0] = THR_W'(126);
    plan[1] = THR_W'(1);
    plan[2] = THR_W'($urandom_range(1, 126));
    plan[3] = THR_W'($urandom_range(1, 126));
    plan[4] = THR_RESET;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_threshold(plan[phase]);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        late = (phase == RANDOM_PHASES - 1) && (n >= ITEMS_PER_PHASE - BACK_TO_BACK_TAIL);
        if (!late && $urandom_range(0, 4) == 0) idle_cycles($urandom_range(1, 8));
        if (phase == 1 && n == ITEMS_PER_PHASE / 2) drain_results();
        if ($urandom_range(0, 99) < 15) begin
          pc = {$urandom, $urandom};
          tk = 1'($urandom_range(0, 1));
        end else begin
          if ($urandom_range(0, 4) == 0) cur = $urandom_range(0, BRANCH_POOL - 1);
          else cur = (cur + 1) % BRANCH_POOL;
          pc = pool_pc[cur];
          case (pool_habit[cur])
            B_ALWAYS:    tk = 1'b1;
            B_NEVER:     tk = 1'b0;
            B_ALTERNATE: tk = 1'(pool_seen[cur] % 2);
            B_LOOP4:     tk = (pool_seen[cur] % 4 != 3);
            B_ECHO2:     tk = recent[1];
            B_XOR:       tk = recent[0] ^ recent[2];
            default:     tk = 1'($urandom_range(0, 1));
          endcase
          pool_seen[cur]++;
        end
        send_branch(pc, tk);
        recent = {recent[6:0], tk};
      end
    end
    idle_cycles(1);
  endtask

  initial begin
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < ROW_WIDTH; c++) weights_m[r][c] = '0;
      tags_m[r] = '0;
    end
    history_m   = '0;
    threshold_m = THR_RESET;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_threshold_extremes();
    test_random_traffic();

    drain_results();
    repeat (LATENCY_SLACK) @(posedge clk);

    $display("Sent %0d branch requests under %0d threshold writes (0, 1, 126, 127 among them),",
             items_sent, settings_written);
    $display("checked %0d results with %0d mispredictions and %0d tag conflicts.",
             results_checked, mispredict_seen, conflict_seen);
    if (error_count == 0 && pending_predictions.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
